>>> rtl/gwah_pkg.sv
// Shared constants, types and helpers of the futex wait address histogram.
package gwah_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int COUNT_WIDTH = 48;

    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W   = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W    = 64;
    localparam int SYSNR_W  = 10;
    localparam int OPW_W    = 32;
    localparam int MARKER_W = 8;
    localparam int ENTRY_W  = 6;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [OPW_W-1:0] OP_MASK            = 32'hFFFF_FE7F;
    localparam logic [OPW_W-1:0] OP_WAIT            = 32'd0;
    localparam logic [OPW_W-1:0] OP_WAIT_BITSET     = 32'd9;
    localparam logic [OPW_W-1:0] OP_WAIT_REQUEUE_PI = 32'd11;

    localparam logic [MARKER_W-1:0] MARK_ACTIVE   = 8'h41;
    localparam logic [MARKER_W-1:0] MARK_COMPLETE = 8'h43;

    localparam logic [SYSNR_W-1:0] FUTEX_NR_RESET = 10'd202;

    localparam logic CMD_MARKER = 1'b0;

    typedef enum logic [2:0] {
        ST_ACK          = 3'd0,
        ST_COUNTED      = 3'd1,
        ST_IGNORED      = 3'd2,
        ST_BAD_ACTIVE   = 3'd3,
        ST_BAD_COMPLETE = 3'd4,
        ST_UNKNOWN      = 3'd5,
        ST_FULL         = 3'd6
    } status_t;

    // Lookup engine response, one-cycle done pulse with its result.
    typedef struct packed {
        logic                   done;
        logic                   full;
        logic                   new_entry;
        logic [COUNT_WIDTH-1:0] count;
    } eng_rsp_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

endpackage

>>> rtl/gwah_ram.sv
// Simple dual-port RAM, one write port and one registered read port.
module gwah_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gwah_engine.sv
// Key table search and per-address count update over the key and count RAMs.
module gwah_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [gwah_pkg::KEY_W-1:0] addr,
    input  logic [gwah_pkg::USED_W-1:0] used,
    output gwah_pkg::eng_rsp_t         rsp
);
    import gwah_pkg::*;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SEARCH,
        E_CNT_RD,
        E_CNT_UPD
    } eng_state_t;

    eng_state_t state_reg, state_next;
    logic [USED_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  sel_idx_reg, sel_idx_next;
    eng_rsp_t          rsp_reg, rsp_next;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [KEY_W-1:0]       key_rdata;
    logic [COUNT_WIDTH-1:0] cnt_rdata;
    logic                   key_we;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] cnt_new;

    gwah_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (wr_idx),
        .wdata (addr),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (key_rdata)
    );

    gwah_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_cnt_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (cnt_wdata),
        .raddr (sel_idx_reg),
        .rdata (cnt_rdata)
    );

    assign hit     = cmp_valid_reg && (key_rdata == addr);
    assign cnt_new = sat_inc(cnt_rdata);

    always_comb begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        sel_idx_next   = sel_idx_reg;
        rsp_next       = '0;
        wr_en          = 1'b0;
        key_we         = 1'b0;
        wr_idx         = sel_idx_reg;
        cnt_wdata      = cnt_new;
        unique case (state_reg)
            E_IDLE: begin
                if (start) begin
                    scan_next  = '0;
                    state_next = E_SEARCH;
                end
            end
            E_SEARCH: begin
                if (hit) begin
                    // the key read last cycle matches: fetch its count
                    sel_idx_next = cmp_idx_reg;
                    state_next   = E_CNT_RD;
                end else if (scan_reg == used) begin
                    if (used == USED_W'(TABLE_DEPTH)) begin
                        rsp_next.done = 1'b1;
                        rsp_next.full = 1'b1;
                    end else begin
                        // append the address with a count of one
                        wr_en              = 1'b1;
                        key_we             = 1'b1;
                        wr_idx             = used[IDX_W-1:0];
                        cnt_wdata          = COUNT_WIDTH'(1);
                        rsp_next.done      = 1'b1;
                        rsp_next.new_entry = 1'b1;
                        rsp_next.count     = COUNT_WIDTH'(1);
                    end
                    state_next = E_IDLE;
                end else begin
                    // issue the next key read, compare it in the cycle after
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    scan_next      = scan_reg + USED_W'(1);
                end
            end
            E_CNT_RD: begin
                state_next = E_CNT_UPD;
            end
            E_CNT_UPD: begin
                wr_en          = 1'b1;
                rsp_next.done  = 1'b1;
                rsp_next.count = cnt_new;
                state_next     = E_IDLE;
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= E_IDLE;
            cmp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            rsp_reg       <= rsp_next;
        end
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        sel_idx_reg <= sel_idx_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/gated_wait_address_histogram_core.sv
// Top level of the gated futex wait address histogram.
//
// Control markers open ('A') and close ('C') a one-shot measurement interval;
// an acknowledged marker is echoed in ack_byte. While the interval is active, a
// syscall item whose number equals the futex register and whose operation word,
// masked with 0xFFFFFE7F, is a wait (0, 9 or 11) is counted per address in a
// 1024-entry key table held in block RAM. Every input item yields exactly one
// result item. A marker or an uncounted event sets up its result, which loads the
// output register once that register is free; then the next item is taken. A
// counted event is searched linearly, one key RAM read per cycle with the compare
// in the cycle after its read. A new address is appended with a count of one, or
// a full table is reported; an address that is found has its count read, updated
// and handed off. The single read port of the key RAM bounds the search. s_ready
// is high only while no item is in work; one finished result may wait in the
// output register while the next item is taken. The futex register may be written
// at any time via cfg_wr_en.
module gated_wait_address_histogram_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gwah_pkg::SYSNR_W-1:0]     cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [gwah_pkg::MARKER_W-1:0]    s_marker_byte,
    input  logic [gwah_pkg::SYSNR_W-1:0]     s_syscall_number,
    input  logic [gwah_pkg::OPW_W-1:0]       s_futex_op_word,
    input  logic [gwah_pkg::KEY_W-1:0]       s_wait_address,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_status,
    output logic [gwah_pkg::MARKER_W-1:0]    m_ack_byte,
    output logic [gwah_pkg::ENTRY_W-1:0]     m_entry_count,
    output logic [gwah_pkg::COUNT_WIDTH-1:0] m_total_attempts,
    output logic [gwah_pkg::USED_W-1:0]      m_distinct_addresses,
    output logic [gwah_pkg::COUNT_WIDTH-1:0] m_max_attempts,
    output logic                             m_started_flag,
    output logic                             m_complete_flag
);
    import gwah_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_PUSH
    } top_state_t;

    top_state_t state_reg, state_next;

    // architectural state
    logic [SYSNR_W-1:0]     futex_reg, futex_next;
    logic                   started_reg, started_next;
    logic                   active_reg, active_next;
    logic                   complete_reg, complete_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] max_reg, max_next;

    // item held for the engine
    logic [KEY_W-1:0]       addr_reg, addr_next;

    // finished result waiting for the output register
    status_t                pend_status_reg, pend_status_next;
    logic [MARKER_W-1:0]    pend_ack_reg, pend_ack_next;
    logic [ENTRY_W-1:0]     pend_entry_reg, pend_entry_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [MARKER_W-1:0]    m_ack_reg, m_ack_next;
    logic [ENTRY_W-1:0]     m_entry_reg, m_entry_next;
    logic [COUNT_WIDTH-1:0] m_total_reg, m_total_next;
    logic [USED_W-1:0]      m_used_reg, m_used_next;
    logic [COUNT_WIDTH-1:0] m_max_reg, m_max_next;
    logic                   m_started_reg, m_started_next;
    logic                   m_complete_reg, m_complete_next;

    logic                   accept;
    logic [OPW_W-1:0]       op_masked;
    logic                   is_wait;
    logic                   counted;
    logic                   eng_start;
    eng_rsp_t               eng_rsp;

    gwah_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eng_start),
        .addr    (addr_reg),
        .used    (used_reg),
        .rsp     (eng_rsp)
    );

    assign s_ready   = (state_reg == T_IDLE);
    assign accept    = s_valid && s_ready;
    assign op_masked = s_futex_op_word & OP_MASK;
    assign is_wait   = (op_masked == OP_WAIT) || (op_masked == OP_WAIT_BITSET) ||
                       (op_masked == OP_WAIT_REQUEUE_PI);
    assign counted   = active_reg && (s_syscall_number == futex_reg) && is_wait;

    always_comb begin
        state_next       = state_reg;
        futex_next       = cfg_wr_en ? cfg_wr_data : futex_reg;
        started_next     = started_reg;
        active_next      = active_reg;
        complete_next    = complete_reg;
        used_next        = used_reg;
        total_next       = total_reg;
        max_next         = max_reg;
        addr_next        = addr_reg;
        pend_status_next = pend_status_reg;
        pend_ack_next    = pend_ack_reg;
        pend_entry_next  = pend_entry_reg;
        eng_start        = 1'b0;

        // drop the shown result once taken
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_ack_next      = m_ack_reg;
        m_entry_next    = m_entry_reg;
        m_total_next    = m_total_reg;
        m_used_next     = m_used_reg;
        m_max_next      = m_max_reg;
        m_started_next  = m_started_reg;
        m_complete_next = m_complete_reg;

        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    pend_ack_next   = '0;
                    pend_entry_next = '0;
                    if (s_command == CMD_MARKER) begin
                        state_next = T_PUSH;
                        if (s_marker_byte == MARK_ACTIVE) begin
                            if (started_reg || complete_reg) begin
                                pend_status_next = ST_BAD_ACTIVE;
                            end else begin
                                started_next     = 1'b1;
                                active_next      = 1'b1;
                                pend_status_next = ST_ACK;
                                pend_ack_next    = s_marker_byte;
                            end
                        end else if (s_marker_byte == MARK_COMPLETE) begin
                            if (!started_reg || complete_reg) begin
                                pend_status_next = ST_BAD_COMPLETE;
                            end else begin
                                active_next      = 1'b0;
                                complete_next    = 1'b1;
                                pend_status_next = ST_ACK;
                                pend_ack_next    = s_marker_byte;
                            end
                        end else begin
                            pend_status_next = ST_UNKNOWN;
                        end
                    end else if (counted) begin
                        // hand the address to the table search
                        addr_next  = s_wait_address;
                        eng_start  = 1'b1;
                        state_next = T_BUSY;
                    end else begin
                        pend_status_next = ST_IGNORED;
                        state_next       = T_PUSH;
                    end
                end
            end
            T_BUSY: begin
                if (eng_rsp.done) begin
                    state_next = T_PUSH;
                    if (eng_rsp.full) begin
                        pend_status_next = ST_FULL;
                    end else begin
                        pend_status_next = ST_COUNTED;
                        pend_entry_next  = eng_rsp.count[ENTRY_W-1:0];
                        total_next       = sat_inc(total_reg);
                        used_next        = used_reg + USED_W'(eng_rsp.new_entry);
                        if (eng_rsp.count > max_reg) begin
                            max_next = eng_rsp.count;
                        end
                    end
                end
            end
            T_PUSH: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = pend_status_reg;
                    m_ack_next      = pend_ack_reg;
                    m_entry_next    = pend_entry_reg;
                    m_total_next    = total_reg;
                    m_used_next     = used_reg;
                    m_max_next      = max_reg;
                    m_started_next  = started_reg;
                    m_complete_next = complete_reg;
                    state_next      = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            futex_reg    <= FUTEX_NR_RESET;
            started_reg  <= 1'b0;
            active_reg   <= 1'b0;
            complete_reg <= 1'b0;
            used_reg     <= '0;
            total_reg    <= '0;
            max_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            futex_reg    <= futex_next;
            started_reg  <= started_next;
            active_reg   <= active_next;
            complete_reg <= complete_next;
            used_reg     <= used_next;
            total_reg    <= total_next;
            max_reg      <= max_next;
            m_valid_reg  <= m_valid_next;
        end
        addr_reg        <= addr_next;
        pend_status_reg <= pend_status_next;
        pend_ack_reg    <= pend_ack_next;
        pend_entry_reg  <= pend_entry_next;
        m_status_reg    <= m_status_next;
        m_ack_reg       <= m_ack_next;
        m_entry_reg     <= m_entry_next;
        m_total_reg     <= m_total_next;
        m_used_reg      <= m_used_next;
        m_max_reg       <= m_max_next;
        m_started_reg   <= m_started_next;
        m_complete_reg  <= m_complete_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_ack_byte           = m_ack_reg;
    assign m_entry_count        = m_entry_reg;
    assign m_total_attempts     = m_total_reg;
    assign m_distinct_addresses = m_used_reg;
    assign m_max_attempts       = m_max_reg;
    assign m_started_flag       = m_started_reg;
    assign m_complete_flag      = m_complete_reg;

endmodule

>>> dv/tb_gated_wait_address_histogram_core.sv
// Self-checking testbench of the futex wait address histogram core.
module tb_gated_wait_address_histogram_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gwah_pkg::*;

    localparam logic CMD_EVENT = ~CMD_MARKER;

    // One input item as it appears on the s_ ports.
    typedef struct packed {
        logic                cmd;
        logic [MARKER_W-1:0] marker;
        logic [SYSNR_W-1:0]  nr;
        logic [OPW_W-1:0]    opw;
        logic [KEY_W-1:0]    addr;
    } sys_item_t;

    // One result item as it appears on the m_ ports.
    typedef struct packed {
        status_t                status;
        logic [MARKER_W-1:0]    ack;
        logic [ENTRY_W-1:0]     entry;
        logic [COUNT_WIDTH-1:0] total;
        logic [USED_W-1:0]      distinct;
        logic [COUNT_WIDTH-1:0] peak;
        logic                   started;
        logic                   complete;
    } tally_t;

    // Directed row: the item, and a hand-written result where one is given.
    typedef struct {
        sys_item_t item;
        bit        typed;
        tally_t    want;
    } dir_row_t;

    localparam tally_t NO_WANT = '{ST_ACK, '0, '0, '0, '0, '0, 1'b0, 1'b0};

    // Clock, reset and every block input start at a known value.
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [SYSNR_W-1:0]     cfg_wr_data = '0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    logic                   s_command   = CMD_MARKER;
    logic [MARKER_W-1:0]    s_marker_byte    = '0;
    logic [SYSNR_W-1:0]     s_syscall_number = '0;
    logic [OPW_W-1:0]       s_futex_op_word  = '0;
    logic [KEY_W-1:0]       s_wait_address   = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    logic [2:0]             m_status;
    logic [MARKER_W-1:0]    m_ack_byte;
    logic [ENTRY_W-1:0]     m_entry_count;
    logic [COUNT_WIDTH-1:0] m_total_attempts;
    logic [USED_W-1:0]      m_distinct_addresses;
    logic [COUNT_WIDTH-1:0] m_max_attempts;
    logic                   m_started_flag;
    logic                   m_complete_flag;

    // Predictor state: the futex register, the interval flags and the
    // per-address wait tallies (the table is an associative array here, since
    // the order of the entries never shows on the ports).
    logic [SYSNR_W-1:0]     futex_nr = FUTEX_NR_RESET;
    bit                     iv_started  = 1'b0;
    bit                     iv_active   = 1'b0;
    bit                     iv_complete = 1'b0;
    logic [COUNT_WIDTH-1:0] total_waits = '0;
    logic [COUNT_WIDTH-1:0] peak_waits  = '0;
    logic [COUNT_WIDTH-1:0] waits_by_addr [logic [KEY_W-1:0]];

    tally_t           expected_q [$];
    dir_row_t         dir_rows [$];
    int               errors = 0;
    int               sender_idle_pct = 0;
    int               stall_pct = 0;
    status_t          last_status;
    logic [KEY_W-1:0] hot_addr [8];
    logic [KEY_W-1:0] warm_addr [48];

    gated_wait_address_histogram_core i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_marker_byte        (s_marker_byte),
        .s_syscall_number     (s_syscall_number),
        .s_futex_op_word      (s_futex_op_word),
        .s_wait_address       (s_wait_address),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_ack_byte           (m_ack_byte),
        .m_entry_count        (m_entry_count),
        .m_total_attempts     (m_total_attempts),
        .m_distinct_addresses (m_distinct_addresses),
        .m_max_attempts       (m_max_attempts),
        .m_started_flag       (m_started_flag),
        .m_complete_flag      (m_complete_flag)
    );

    always #6 aclk = ~aclk;

    // Advance the histogram by one item and return the result it must give.
    function automatic tally_t tally_item(input sys_item_t it);
        tally_t                 r;
        logic [OPW_W-1:0]       op;
        logic                   is_wait;
        logic [COUNT_WIDTH-1:0] n;
        r = NO_WANT;
        if (it.cmd == CMD_MARKER) begin
            if (it.marker == MARK_ACTIVE) begin
                // The interval opens once only.
                if (iv_started || iv_complete) begin
                    r.status = ST_BAD_ACTIVE;
                end else begin
                    iv_started = 1'b1;
                    iv_active  = 1'b1;
                    r.status   = ST_ACK;
                end
            end else if (it.marker == MARK_COMPLETE) begin
                if (!iv_started || iv_complete) begin
                    r.status = ST_BAD_COMPLETE;
                end else begin
                    iv_active   = 1'b0;
                    iv_complete = 1'b1;
                    r.status    = ST_ACK;
                end
            end else begin
                r.status = ST_UNKNOWN;
            end
            if (r.status == ST_ACK) r.ack = it.marker;
        end else begin
            // Drop the private and clock flags before matching the wait codes.
            op      = it.opw & OP_MASK;
            is_wait = (op == OP_WAIT) || (op == OP_WAIT_BITSET) || (op == OP_WAIT_REQUEUE_PI);
            if (!iv_active || it.nr != futex_nr || !is_wait) begin
                r.status = ST_IGNORED;
            end else if (!waits_by_addr.exists(it.addr) &&
                         waits_by_addr.num() >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                n = waits_by_addr.exists(it.addr) ? waits_by_addr[it.addr] : '0;
                if (n != COUNT_MAX) n = n + 1'b1;
                waits_by_addr[it.addr] = n;
                if (total_waits != COUNT_MAX) total_waits = total_waits + 1'b1;
                if (n > peak_waits) peak_waits = n;
                r.status = ST_COUNTED;
                r.entry  = n[ENTRY_W-1:0];
            end
        end
        r.total    = total_waits;
        r.distinct = USED_W'(waits_by_addr.num());
        r.peak     = peak_waits;
        r.started  = iv_started;
        r.complete = iv_complete;
        return r;
    endfunction

    // Marker item; the unused fields carry noise.
    function automatic sys_item_t marker_item(input logic [MARKER_W-1:0] b);
        return '{CMD_MARKER, b, SYSNR_W'($urandom), OPW_W'($urandom), {$urandom, $urandom}};
    endfunction

    function automatic sys_item_t event_item(input logic [SYSNR_W-1:0] nr,
                                             input logic [OPW_W-1:0] opw,
                                             input logic [KEY_W-1:0] addr);
        return '{CMD_EVENT, MARKER_W'($urandom), nr, opw, addr};
    endfunction

    // A wait code with random private / clock-realtime flag bits.
    function automatic logic [OPW_W-1:0] wait_op();
        logic [OPW_W-1:0] code;
        case ($urandom_range(2))
            0:       code = OP_WAIT;
            1:       code = OP_WAIT_BITSET;
            default: code = OP_WAIT_REQUEUE_PI;
        endcase
        return code | (OPW_W'($urandom_range(3)) << 7);
    endfunction

    // Skew addresses toward a few hot ones so per-address counts pass 64
    // and the table stays short enough to search quickly.
    function automatic logic [KEY_W-1:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 35) return hot_addr[0];
        if (r < 55) return hot_addr[$urandom_range(7)];
        if (r < 80) return warm_addr[$urandom_range(47)];
        return {$urandom, $urandom};
    endfunction

    // Present one item from a falling edge, hold it until accepted, then
    // record its expected result. Returns at the falling edge after acceptance
    // with valid still high, so the caller either drives the next item or drops.
    task automatic offer_item(input sys_item_t it, input bit typed, input tally_t want);
        tally_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= it.cmd;
        s_marker_byte    <= it.marker;
        s_syscall_number <= it.nr;
        s_futex_op_word  <= it.opw;
        s_wait_address   <= it.addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = tally_item(it);
        expected_q.push_back(typed ? want : predicted);
        last_status = predicted.status;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Write the futex register with the block idle.
    task automatic write_futex_nr(input logic [SYSNR_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        futex_nr     = v;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Receiver: stall at random when a stall share is set.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        tally_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t ns: result item with none expected, status %0d", $time, m_status);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("status", want.status, m_status);
                check_field("ack_byte", want.ack, m_ack_byte);
                check_field("entry_count", want.entry, m_entry_count);
                check_field("total_attempts", want.total, m_total_attempts);
                check_field("distinct_addresses", want.distinct, m_distinct_addresses);
                check_field("max_attempts", want.peak, m_max_attempts);
                check_field("started_flag", want.started, m_started_flag);
                check_field("complete_flag", want.complete, m_complete_flag);
            end
        end
    end

    // Hard stop: many times beyond the slowest correct run.
    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [SYSNR_W-1:0] phase_nr [4];
        int                 phase_idle [4];
        int                 phase_stall [4];
        int                 busy_items;
        int                 r;
        int                 k;
        sys_item_t          it;

        foreach (hot_addr[i]) hot_addr[i] = {$urandom, $urandom};
        foreach (warm_addr[i]) warm_addr[i] = {$urandom, $urandom};

        // Register settings and idling per random phase: extremes first.
        phase_nr    = '{10'd0, 10'd1023, SYSNR_W'($urandom), FUTEX_NR_RESET};
        phase_idle  = '{0, 56, 0, 27};
        phase_stall = '{0, 0, 56, 27};

        // Directed table. Before the interval opens nothing is counted and
        // bad markers leave all state at zero; right after the start marker
        // the first counts can be read off directly.
        dir_rows.push_back('{marker_item(MARK_COMPLETE), 1'b1,
            '{ST_BAD_COMPLETE, 8'h00, 6'd0, 48'd0, 11'd0, 48'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{marker_item(8'h00), 1'b1,
            '{ST_UNKNOWN, 8'h00, 6'd0, 48'd0, 11'd0, 48'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{marker_item(8'hFF), 1'b1,
            '{ST_UNKNOWN, 8'h00, 6'd0, 48'd0, 11'd0, 48'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, OP_WAIT, 64'd0), 1'b1,
            '{ST_IGNORED, 8'h00, 6'd0, 48'd0, 11'd0, 48'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{marker_item(MARK_ACTIVE), 1'b1,
            '{ST_ACK, MARK_ACTIVE, 6'd0, 48'd0, 11'd0, 48'd0, 1'b1, 1'b0}});
        dir_rows.push_back('{marker_item(MARK_ACTIVE), 1'b1,
            '{ST_BAD_ACTIVE, 8'h00, 6'd0, 48'd0, 11'd0, 48'd0, 1'b1, 1'b0}});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, OP_WAIT, 64'd0), 1'b1,
            '{ST_COUNTED, 8'h00, 6'd1, 48'd1, 11'd1, 48'd1, 1'b1, 1'b0}});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, OP_WAIT_BITSET, {KEY_W{1'b1}}), 1'b1,
            '{ST_COUNTED, 8'h00, 6'd1, 48'd2, 11'd2, 48'd1, 1'b1, 1'b0}});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, OP_WAIT_REQUEUE_PI, 64'd0), 1'b1,
            '{ST_COUNTED, 8'h00, 6'd2, 48'd3, 11'd2, 48'd2, 1'b1, 1'b0}});
        // Flag bits in the mask hole must not stop a wait from counting.
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'h0000_0180, 64'd0), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'h0000_0189, {KEY_W{1'b1}}),
                             1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'h0000_010B,
                             64'h5555_5555_5555_5555), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'h0000_0080,
                             64'h5555_5555_5555_5555), 1'b0, NO_WANT});
        // Operations that are not waits.
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'd1, 64'd0), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'hFFFF_FFFF, 64'd0), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'h8000_0000, {KEY_W{1'b1}}),
                             1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'h0000_0200, 64'd0), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(FUTEX_NR_RESET, 32'd10, 64'd0), 1'b0, NO_WANT});
        // Syscall numbers other than the register.
        dir_rows.push_back('{event_item(FUTEX_NR_RESET + 1'b1, OP_WAIT, 64'd0), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(10'd0, OP_WAIT, 64'd0), 1'b0, NO_WANT});
        dir_rows.push_back('{event_item(10'd1023, OP_WAIT_BITSET, {KEY_W{1'b1}}),
                             1'b0, NO_WANT});
        // The command bit alone decides marker versus event.
        dir_rows.push_back('{'{CMD_MARKER, 8'hFF, 10'h3FF, 32'hFFFF_FFFF, {KEY_W{1'b1}}},
                             1'b0, NO_WANT});
        dir_rows.push_back('{'{CMD_EVENT, MARK_COMPLETE, FUTEX_NR_RESET, OP_WAIT,
                               64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, NO_WANT});
        dir_rows.push_back('{'{CMD_MARKER, MARK_ACTIVE, FUTEX_NR_RESET, OP_WAIT, 64'd0},
                             1'b0, NO_WANT});

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part runs on the reset value of the futex register.
        foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        // Random part: the interval stays open, so keep most items countable
        // waits on known addresses; the rest is noise, near misses and
        // markers that must be refused.
        for (int ph = 0; ph < 4; ph++) begin
            write_futex_nr(phase_nr[ph]);
            sender_idle_pct = phase_idle[ph];
            stall_pct       = phase_stall[ph];
            busy_items      = 0;
            while (busy_items < 108) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    it = event_item(futex_nr, wait_op(), pick_address());
                end else if (r < 80) begin
                    it = event_item(SYSNR_W'($urandom), OPW_W'($urandom), {$urandom, $urandom});
                end else if (r < 86) begin
                    it = event_item(futex_nr ^ (SYSNR_W'(1) << $urandom_range(9)), wait_op(),
                                    pick_address());
                end else if (r < 90) begin
                    // Set one bit outside the flag hole.
                    k = $urandom_range(31);
                    if (k == 7 || k == 8) k = 31;
                    it = event_item(futex_nr, wait_op() | (OPW_W'(1) << k), pick_address());
                end else if (r < 97) begin
                    it = marker_item(MARKER_W'($urandom));
                    // Hold the interval open until the closing sequence.
                    if (it.marker == MARK_COMPLETE) it.marker = MARK_ACTIVE;
                end else begin
                    it = marker_item(MARK_ACTIVE);
                end
                offer_item(it, 1'b0, NO_WANT);
                if (last_status != ST_IGNORED) busy_items++;
            end
        end

        // Close the interval, then check that it cannot be reopened or
        // closed again and that waits no longer count.
        sender_idle_pct = 27;
        stall_pct       = 27;
        offer_item(marker_item(MARK_COMPLETE), 1'b0, NO_WANT);
        offer_item(marker_item(MARK_COMPLETE), 1'b0, NO_WANT);
        offer_item(marker_item(MARK_ACTIVE), 1'b0, NO_WANT);
        offer_item(event_item(futex_nr, wait_op(), hot_addr[0]), 1'b0, NO_WANT);
        repeat (8) begin
            if ($urandom_range(1))
                offer_item(marker_item(MARKER_W'($urandom)), 1'b0, NO_WANT);
            else
                offer_item(event_item(futex_nr, wait_op(), pick_address()), 1'b0, NO_WANT);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/gwah_pkg.sv
rtl/gwah_ram.sv
rtl/gwah_engine.sv
rtl/gated_wait_address_histogram_core.sv
dv/tb_gated_wait_address_histogram_core.sv
